/* rtl/irmt_pkg.sv */
// irmt_pkg: shared types and constants of the ID range map translator.
// No dependencies; imported by every module of the block.

package irmt_pkg;

    localparam int ID_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDENTITY_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_ID   = 2'd1;

    localparam logic [ID_W-1:0] UNMAPPED_ID_RESET = 32'd65534;

    typedef enum logic [2:0] {
        OP_ADD_USER  = 3'd0,
        OP_ADD_GROUP = 3'd1,
        OP_IN2OUT_U  = 3'd2,
        OP_IN2OUT_G  = 3'd3,
        OP_OUT2IN_U  = 3'd4,
        OP_OUT2IN_G  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_PERM = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIX,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [2:0]      op;
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] first_inside;
        logic [ID_W-1:0] first_outside;
        logic [ID_W-1:0] range_length;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0] inside_start;
        logic [ID_W-1:0] outside_start;
        logic [ID_W-1:0] range_length;
    } entry_t;

    typedef struct packed {
        status_t         status;
        logic [ID_W-1:0] id_out;
        logic            matched;
    } result_t;

endpackage

/* rtl/id_range_map_translator_top.sv */
// A lookup walks the table from its first entry and stops at the first match or after the
// last entry held; an add, a reserved operation, an identity-mode word or a lookup on an
// empty table goes straight to the response. The table memory delivers one entry per cycle,
// which sets the walk. User and group tables share one memory, each holding MAP_ENTRIES
// entries. A new word is taken while the previous result waits in the output register.
//
// id_range_map_translator_top: top level with config registers and output register.
// Instantiates irmt_engine; uses irmt_pkg.

module id_range_map_translator_top
    import irmt_pkg::*;
#(
    parameter int MAP_ENTRIES = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ID_W-1:0]      cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [127:0]         s_axis_tdata,  // id_in, first_inside, first_outside, range_length
    input  logic [2:0]           s_axis_tuser,  // operation
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [ID_W-1:0]      m_axis_tdata,  // id_out
    output logic [2:0]           m_axis_tuser   // status, matched
);

    logic            identity_mode_reg;
    logic [ID_W-1:0] unmapped_id_reg;
    logic            m_valid_reg, m_valid_next;
    result_t         m_res_reg;
    item_t           in_item;
    logic            res_valid;
    logic            res_ready;
    result_t         res;

    assign in_item = '{op:            s_axis_tuser,
                       id:            s_axis_tdata[31:0],
                       first_inside:  s_axis_tdata[63:32],
                       first_outside: s_axis_tdata[95:64],
                       range_length:  s_axis_tdata[127:96]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            identity_mode_reg <= 1'b0;
            unmapped_id_reg   <= UNMAPPED_ID_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDENTITY_MODE: identity_mode_reg <= cfg_data[0];
                CFG_UNMAPPED_ID:   unmapped_id_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    irmt_engine #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .identity_mode (identity_mode_reg),
        .unmapped_id   (unmapped_id_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_item       (in_item),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    assign res_ready    = !m_valid_reg || m_axis_tready;
    assign m_valid_next = res_valid || (m_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_res_reg.id_out;
    assign m_axis_tuser  = {m_res_reg.matched, m_res_reg.status};

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("engine took a second word while busy");

    a_match_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == ST_OK)
        else $error("matched result carries an error status");

    a_identity_never_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && identity_mode_reg |-> m_axis_tuser[1:0] != ST_FULL)
        else $error("table full reported in identity mode");

endmodule

/* rtl/irmt_table_mem.sv */
// irmt_table_mem: range entry storage for the user and group tables.
// One write port, one read port, registered read data. Uses irmt_pkg.

module irmt_table_mem
    import irmt_pkg::*;
#(
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  entry_t            wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output entry_t            rdata
);

    entry_t mem [2**ADDR_W];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/irmt_engine.sv */
// irmt_engine: sequencer that appends entries and walks the table memory.
// Instantiates irmt_table_mem; uses irmt_pkg.

module irmt_engine
    import irmt_pkg::*;
#(
    parameter int MAP_ENTRIES = 5
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            identity_mode,
    input  logic [ID_W-1:0] unmapped_id,
    input  logic            in_valid,
    output logic            in_ready,
    input  item_t           in_item,
    output logic            res_valid,
    input  logic            res_ready,
    output result_t         res
);

    localparam int IDX_W  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAP_ENTRIES + 1) > 0 ? $clog2(MAP_ENTRIES + 1) : 1;
    localparam int ADDR_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAP_ENTRIES);

    state_t              state_reg, state_next;
    item_t               item_reg, item_next;
    logic [CNT_W-1:0]    used_user_reg, used_user_next;
    logic [CNT_W-1:0]    used_group_reg, used_group_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [ID_W-1:0]     to_reg, to_next;
    logic [ID_W-1:0]     diff_reg, diff_next;
    result_t             res_reg, res_next;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    entry_t              mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    entry_t              mem_rdata;

    irmt_table_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_user_reg  <= '0;
            used_group_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            used_user_reg  <= used_user_next;
            used_group_reg <= used_group_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        idx_reg  <= idx_next;
        to_reg   <= to_next;
        diff_reg <= diff_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        logic             in_grp;
        logic             scan_grp;
        logic [CNT_W-1:0] in_used;
        logic [CNT_W-1:0] scan_used;
        logic             out2in;
        logic [ID_W-1:0]  from_id;
        logic [ID_W-1:0]  to_id;
        logic [ID_W-1:0]  end_id;

        state_next      = state_reg;
        item_next       = item_reg;
        used_user_next  = used_user_reg;
        used_group_next = used_group_reg;
        idx_next        = idx_reg;
        to_next         = to_reg;
        diff_next       = diff_reg;
        res_next        = res_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        in_grp    = in_item.op[0];
        in_used   = in_grp ? used_group_reg : used_user_reg;
        scan_grp  = item_reg.op[0];
        scan_used = scan_grp ? used_group_reg : used_user_reg;
        out2in    = (item_reg.op == OP_OUT2IN_U) || (item_reg.op == OP_OUT2IN_G);
        from_id   = out2in ? mem_rdata.outside_start : mem_rdata.inside_start;
        to_id     = out2in ? mem_rdata.inside_start : mem_rdata.outside_start;
        end_id    = from_id + mem_rdata.range_length;

        mem_waddr = {in_grp, in_used[IDX_W-1:0]};
        mem_wdata = '{inside_start:  in_item.first_inside,
                      outside_start: in_item.first_outside,
                      range_length:  in_item.range_length};
        mem_raddr = {in_grp, {IDX_W{1'b0}}};

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next  = in_item;
                    idx_next   = '0;
                    res_next   = '{status: ST_OK, id_out: '0, matched: 1'b0};
                    state_next = S_RESP;
                    case (op_t'(in_item.op))
                        OP_ADD_USER, OP_ADD_GROUP:
                        begin
                            if (identity_mode)
                            begin
                                res_next.status = ST_PERM;
                            end
                            else if (in_used == FULL_CNT)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                if (in_grp)
                                begin
                                    used_group_next = used_group_reg + 1'b1;
                                end
                                else
                                begin
                                    used_user_next = used_user_reg + 1'b1;
                                end
                            end
                        end
                        OP_IN2OUT_U, OP_IN2OUT_G, OP_OUT2IN_U, OP_OUT2IN_G:
                        begin
                            if (identity_mode)
                            begin
                                res_next.id_out  = in_item.id;
                                res_next.matched = 1'b1;
                            end
                            else if (in_used == '0)
                            begin
                                res_next.id_out = unmapped_id;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                mem_raddr = {scan_grp, idx_reg + 1'b1};
                if ((item_reg.id >= from_id) && (item_reg.id < end_id))
                begin
                    to_next    = to_id;
                    diff_next  = item_reg.id - from_id;
                    state_next = S_FIX;
                end
                else if ((CNT_W'(idx_reg) + 1'b1) == scan_used)
                begin
                    res_next.id_out = unmapped_id;
                    state_next      = S_RESP;
                end
                else
                begin
                    mem_re   = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FIX:
            begin
                res_next.id_out  = to_reg + diff_reg;
                res_next.matched = 1'b1;
                state_next       = S_RESP;
            end
            S_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

/* dv/tb.sv */
// tb: self-checking testbench for id_range_map_translator_top (user/group ID range tables).
// Streams add, lookup and reserved-op words, predicts each result and compares it field
// by field. Depends on rtl/irmt_pkg.sv and rtl/id_range_map_translator_top.sv.
`timescale 1ns / 100ps

module tb;
    import irmt_pkg::*;

    localparam int MAP_N = 5;
    localparam int HOLD_AT = 350;
    localparam int HOLD_LEN = 400;
    localparam int PHASE_ITEMS = 100;

    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

    localparam int T_USER = 0;
    localparam int T_GROUP = 1;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ID_W-1:0]      cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [127:0]         s_axis_tdata = '0;
    logic [2:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [ID_W-1:0]      m_axis_tdata;
    logic [2:0]           m_axis_tuser;

    id_range_map_translator_top #(.MAP_ENTRIES(MAP_N)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // shadow of the block's tables and registers
    logic [ID_W-1:0] tab_in  [2][MAP_N];
    logic [ID_W-1:0] tab_out [2][MAP_N];
    logic [ID_W-1:0] tab_len [2][MAP_N];
    int              tab_used [2] = '{0, 0};
    bit              ident_mode = 1'b0;
    logic [ID_W-1:0] unmapped_val = UNMAPPED_ID_RESET;

    item_t   req_q[$];
    result_t answer_q[$];

    int  fails = 0;
    int  words_out = 0;
    bit  idle_on = 1'b1;
    bit  acc_seen = 1'b0;
    bit  out_seen = 1'b0;
    int  src_left = 0;
    int  snk_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int draw_wait();
        if (!idle_on || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    function automatic item_t mk(input logic [2:0] op, input logic [ID_W-1:0] id,
                                 input logic [ID_W-1:0] fi, input logic [ID_W-1:0] fo,
                                 input logic [ID_W-1:0] len);
        item_t it;
        it.op = op;
        it.id = id;
        it.first_inside = fi;
        it.first_outside = fo;
        it.range_length = len;
        return it;
    endfunction

    // expected answer for one word; adds update the shadow tables
    function automatic result_t compute_answer(input item_t it);
        result_t r;
        int t;
        bit rev;
        bit hit;
        logic [ID_W-1:0] from, to, stop;
        r.status = ST_OK;
        r.id_out = '0;
        r.matched = 1'b0;
        case (it.op)
            OP_ADD_USER, OP_ADD_GROUP:
            begin
                t = (it.op == OP_ADD_USER) ? T_USER : T_GROUP;
                if (ident_mode)
                    r.status = ST_PERM;
                else if (tab_used[t] >= MAP_N)
                    r.status = ST_FULL;
                else
                begin
                    tab_in[t][tab_used[t]] = it.first_inside;
                    tab_out[t][tab_used[t]] = it.first_outside;
                    tab_len[t][tab_used[t]] = it.range_length;
                    tab_used[t]++;
                end
            end
            OP_IN2OUT_U, OP_IN2OUT_G, OP_OUT2IN_U, OP_OUT2IN_G:
            begin
                if (ident_mode)
                begin
                    r.id_out = it.id;
                    r.matched = 1'b1;
                end
                else
                begin
                    t = (it.op == OP_IN2OUT_U || it.op == OP_OUT2IN_U) ? T_USER : T_GROUP;
                    rev = (it.op == OP_OUT2IN_U || it.op == OP_OUT2IN_G);
                    hit = 1'b0;
                    r.id_out = unmapped_val;
                    for (int k = 0; k < tab_used[t]; k++)
                    begin
                        from = rev ? tab_out[t][k] : tab_in[t][k];
                        to = rev ? tab_in[t][k] : tab_out[t][k];
                        stop = from + tab_len[t][k];
                        if (!hit && it.id >= from && it.id < stop)
                        begin
                            hit = 1'b1;
                            r.id_out = to + (it.id - from);
                            r.matched = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // lookup ID aimed at the edges of a held range, or anywhere
    function automatic logic [ID_W-1:0] pick_id(input int t, input bit rev);
        int k;
        logic [ID_W-1:0] from, len;
        if (tab_used[t] == 0 || $urandom_range(0, 4) == 0)
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return '1;
                default: return $urandom();
            endcase
        end
        k = $urandom_range(0, tab_used[t] - 1);
        from = rev ? tab_out[t][k] : tab_in[t][k];
        len = tab_len[t][k];
        case ($urandom_range(0, 4))
            0: return from;
            1: return from + len - 1;
            2: return from + len;
            3: return from - 1;
            default: return from + ((len == 0) ? 32'd0 : $urandom() % len);
        endcase
    endfunction

    function automatic item_t random_item();
        item_t it;
        int r;
        it.id = $urandom();
        it.first_inside = $urandom();
        it.first_outside = $urandom();
        it.range_length = $urandom();
        r = $urandom_range(0, 99);
        if (r < 7)
        begin
            it.op = $urandom_range(0, 1) ? OP_ADD_GROUP : OP_ADD_USER;
            case ($urandom_range(0, 3))
                0: it.range_length = $urandom_range(1, 4096);
                1: it.range_length = '0;
                2: it.range_length = '1;
                default: ;
            endcase
        end
        else if (r < 10)
            it.op = $urandom_range(0, 1) ? OP_RSVD7 : OP_RSVD6;
        else
        begin
            case ($urandom_range(0, 3))
                0: it.op = OP_IN2OUT_U;
                1: it.op = OP_IN2OUT_G;
                2: it.op = OP_OUT2IN_U;
                default: it.op = OP_OUT2IN_G;
            endcase
            it.id = pick_id((it.op == OP_IN2OUT_U || it.op == OP_OUT2IN_U) ? T_USER : T_GROUP,
                            it.op == OP_OUT2IN_U || it.op == OP_OUT2IN_G);
        end
        return it;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_IDENTITY_MODE: ident_mode = val[0];
            CFG_UNMAPPED_ID: unmapped_val = val;
            default: ;
        endcase
    endtask

    task automatic set_mode(input bit idm, input logic [ID_W-1:0] unm);
        logic [ID_W-1:0] dv;
        dv = $urandom();
        dv[0] = idm;
        cfg_write(CFG_IDENTITY_MODE, dv);
        cfg_write(CFG_UNMAPPED_ID, unm);
        cfg_write($urandom_range(0, 1) ? CFG_SPARE3 : CFG_SPARE2, $urandom());
    endtask

    task automatic drain();
        while (req_q.size() != 0 || s_axis_tvalid || answer_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // word source
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || acc_seen))
        begin
            if (src_left > 0)
            begin
                src_left <= src_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (req_q.size() != 0)
            begin : launch
                item_t it;
                it = req_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {it.range_length, it.first_outside, it.first_inside, it.id};
                s_axis_tuser <= it.op;
                src_left <= draw_wait();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result sink, with one long hold-off to back the block up
    always @(negedge clk)
    begin : sink
        int w;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (words_out == HOLD_AT && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end
        else if (out_seen)
        begin
            w = draw_wait();
            m_axis_tready <= (w == 0);
            snk_left <= (w == 0) ? 0 : w - 1;
        end
        else if (snk_left > 0)
        begin
            snk_left <= snk_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // prediction on accepted words, check on delivered results
    always @(posedge clk)
    begin : mon
        item_t   it;
        result_t er;
        acc_seen <= s_axis_tvalid && s_axis_tready;
        out_seen <= m_axis_tvalid && m_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            it.op = s_axis_tuser;
            it.id = s_axis_tdata[31:0];
            it.first_inside = s_axis_tdata[63:32];
            it.first_outside = s_axis_tdata[95:64];
            it.range_length = s_axis_tdata[127:96];
            answer_q.push_back(compute_answer(it));
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_out <= words_out + 1;
            if (answer_q.size() == 0)
            begin
                $display("%0t: result with none expected: id_out %h tuser %b",
                         $time, m_axis_tdata, m_axis_tuser);
                fails++;
            end
            else
            begin
                er = answer_q.pop_front();
                if (m_axis_tuser[1:0] !== er.status)
                begin
                    $display("%0t: status exp %0d act %0d", $time, er.status, m_axis_tuser[1:0]);
                    fails++;
                end
                if (m_axis_tdata !== er.id_out)
                begin
                    $display("%0t: id_out exp %h act %h", $time, er.id_out, m_axis_tdata);
                    fails++;
                end
                if (m_axis_tuser[2] !== er.matched)
                begin
                    $display("%0t: matched exp %0d act %0d", $time, er.matched, m_axis_tuser[2]);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty tables, reserved ops
        req_q.push_back(mk(OP_IN2OUT_U, 32'h0, 32'h0, 32'h0, 32'h0));
        req_q.push_back(mk(OP_OUT2IN_G, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF));
        req_q.push_back(mk(OP_RSVD6, 32'h1234_5678, 32'h1, 32'h2, 32'h3));
        req_q.push_back(mk(OP_RSVD7, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
        // user: base, overlap with wrapping outside end, wrapping inside end, zero length
        req_q.push_back(mk(OP_ADD_USER, 32'h0, 32'd0, 32'd100000, 32'd1000));
        req_q.push_back(mk(OP_ADD_USER, 32'h0, 32'd500, 32'hFFFF_FF00, 32'h200));
        req_q.push_back(mk(OP_ADD_USER, 32'h0, 32'hFFFF_FFF0, 32'd5, 32'h10));
        req_q.push_back(mk(OP_ADD_USER, 32'h0, 32'd2000, 32'd3000, 32'd0));
        req_q.push_back(mk(OP_IN2OUT_U, 32'd999, 32'h0, 32'h0, 32'h0));
        req_q.push_back(mk(OP_IN2OUT_U, 32'd1000, 32'h0, 32'h0, 32'h0));
        req_q.push_back(mk(OP_IN2OUT_U, 32'hFFFF_FFF5, 32'h0, 32'h0, 32'h0));
        req_q.push_back(mk(OP_OUT2IN_U, 32'd5, 32'h0, 32'h0, 32'h0));
        req_q.push_back(mk(OP_OUT2IN_U, 32'hFFFF_FF10, 32'h0, 32'h0, 32'h0));
        req_q.push_back(mk(OP_OUT2IN_U, 32'd3000, 32'h0, 32'h0, 32'h0));
        // group: first match wins over a near-full-space entry
        req_q.push_back(mk(OP_ADD_GROUP, 32'h0, 32'h1_0000, 32'h2_0000, 32'h1_0000));
        req_q.push_back(mk(OP_ADD_GROUP, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF));
        req_q.push_back(mk(OP_IN2OUT_G, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
        req_q.push_back(mk(OP_OUT2IN_G, 32'h2_FFFF, 32'h0, 32'h0, 32'h0));
        req_q.push_back(mk(OP_IN2OUT_G, 32'h1_0000, 32'h0, 32'h0, 32'h0));
        drain();

        set_mode(1'b1, 32'hFFFF_FFFF);
        req_q.push_back(mk(OP_ADD_USER, 32'h0, 32'h7, 32'h7, 32'h7));
        req_q.push_back(mk(OP_ADD_GROUP, 32'h0, 32'h7, 32'h7, 32'h7));
        req_q.push_back(mk(OP_OUT2IN_U, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
        req_q.push_back(mk(OP_IN2OUT_G, 32'h0, 32'h0, 32'h0, 32'h0));
        drain();

        set_mode(1'b0, 32'h0);
        req_q.push_back(mk(OP_IN2OUT_U, 32'hFFFF_FFF5, 32'h0, 32'h0, 32'h0));
        req_q.push_back(mk(OP_ADD_USER, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        req_q.push_back(mk(OP_ADD_USER, 32'h0, 32'h1, 32'h1, 32'h1));
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_mode(1'b0, $urandom());
                1: set_mode(1'b0, 32'h0);
                2: set_mode(1'b1, 32'hFFFF_FFFF);
                3: set_mode(1'b0, 32'hFFFF_FFFF);
                4: set_mode(1'b0, $urandom());
                default: set_mode(1'b1, $urandom());
            endcase
            idle_on = (ph != 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                req_q.push_back(random_item());
            drain();
        end

        if (answer_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, answer_q.size());
            fails++;
        end
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
